// File: rtl/core/hs_pkg.sv
// shared types and constants of the heap sorter
`timescale 1ns / 1ps
`default_nettype none

package hs_pkg;

  localparam int unsigned VALUE_W          = 32;
  localparam int unsigned RANK_W           = 6;
  localparam int unsigned MAX_ELEMENTS_DEF = 64;

  // element store read address source
  typedef enum logic [2:0] {
    RD_POS,
    RD_KID_LEFT,
    RD_KID_RIGHT,
    RD_ROOT,
    RD_ITER,
    RD_OUT
  } hs_rd_e;

  // element store write address and data source
  typedef enum logic [1:0] {
    WR_POS_CHILD,
    WR_POS_HELD,
    WR_ROOT_RDATA,
    WR_ITER_HELD
  } hs_wr_e;

  typedef struct packed {
    logic   accept;
    hs_rd_e rd_sel;
    logic   wr_en;
    hs_wr_e wr_sel;
    logic   held_ld;
    logic   cval_ld_left;
    logic   cval_ld_right;
    logic   step_down;
    logic   sift_build;
    logic   sift_extract;
    logic   iter_ld_half;
    logic   iter_ld_count;
    logic   out_k_clr;
    logic   out_k_inc;
    logic   out_load;
    logic   set_clear;
  } hs_cmd_t;

  typedef struct packed {
    logic kid_gt_size;
    logic kid_lt_size;
    logic held_lt_cval;
    logic iter_zero;
    logic iter_lt2;
    logic out_free;
    logic out_last;
  } hs_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/hs_if.sv
// valid/ready channel interfaces for sorter input and output
`timescale 1ns / 1ps
`default_nettype none

interface hs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_value;
  logic        is_final;

  modport source (output valid, output sample_value, output is_final, input ready);
  modport sink   (input valid, input sample_value, input is_final, output ready);
endinterface

interface hs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sorted_value;
  logic [5:0]  rank;
  logic        final_out;
  logic        overflowed;

  modport source (output valid, output sorted_value, output rank, output final_out,
                  output overflowed, input ready);
  modport sink   (input valid, input sorted_value, input rank, input final_out,
                  input overflowed, output ready);
endinterface

`default_nettype wire

// File: rtl/core/heap_sorter_core.sv
// heap sorter top level: collects a set, heapsorts it in place, streams it out ascending
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   sample_value[31:0] signed, is_final
//   out_o    out  valid/ready   sorted_value[31:0] signed, rank[5:0], final_out, overflowed
//
// collecting accepts one transaction per cycle; a final transaction starts the sort
// each sift-down level tests, reads the left and any right child, then compares
// the store is read at most once per cycle; results are read and loaded one by one
// no input is taken from the final transaction until the last result is loaded
// reset clears the count and overflow flag; the element store needs no clearing
// out_o.ready low while a result waits holds the sequencer before the next result is read
`timescale 1ns / 1ps
`default_nettype none

module heap_sorter_core #(
  parameter int unsigned MAX_ELEMENTS = hs_pkg::MAX_ELEMENTS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hs_in_if.sink     in_i,
  hs_out_if.source  out_o
);
  import hs_pkg::*;

  hs_cmd_t cmd;
  hs_sts_t sts;

  hs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_final_i (in_i.is_final),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  hs_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_value_i  (in_i.sample_value),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_value_o (out_o.sorted_value),
    .out_rank_o  (out_o.rank),
    .out_final_o (out_o.final_out),
    .out_ovf_o   (out_o.overflowed)
  );

endmodule

`default_nettype wire

// File: rtl/core/hs_datapath.sv
// element store, sift-down registers and output register of the heap sorter
`timescale 1ns / 1ps
`default_nettype none

module hs_datapath #(
  parameter int unsigned MAX_ELEMENTS = hs_pkg::MAX_ELEMENTS_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire hs_pkg::hs_cmd_t cmd_i,
  output hs_pkg::hs_sts_t     sts_o,
  input  wire logic [31:0]    in_value_i,
  input  wire logic           out_ready_i,
  output logic                out_valid_o,
  output logic [31:0]         out_value_o,
  output logic [5:0]          out_rank_o,
  output logic                out_final_o,
  output logic                out_ovf_o
);
  import hs_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned KW = CW + 1;

  logic [VALUE_W-1:0] mem_q [MAX_ELEMENTS];
  logic [VALUE_W-1:0] rdata_q;

  logic [CW-1:0]      count_q;
  logic               drop_q;
  logic [CW-1:0]      pos_q;
  logic [CW-1:0]      size_q;
  logic [KW-1:0]      kid_q;
  logic [CW-1:0]      cidx_q;
  logic [CW-1:0]      iter_q;
  logic [VALUE_W-1:0] held_q;
  logic [VALUE_W-1:0] cval_q;
  logic [AW-1:0]      out_k_q;

  logic               out_valid_q;
  logic [VALUE_W-1:0] out_value_q;
  logic [RANK_W-1:0]  out_rank_q;
  logic               out_final_q;
  logic               out_ovf_q;

  logic               full;
  logic [AW-1:0]      raddr;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [VALUE_W-1:0] wdata;

  assign full = (count_q == CW'(MAX_ELEMENTS));

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_POS:       raddr = AW'(pos_q - CW'(1));
      RD_KID_LEFT:  raddr = AW'(kid_q - KW'(1));
      RD_KID_RIGHT: raddr = AW'(kid_q);
      RD_ROOT:      raddr = '0;
      RD_ITER:      raddr = AW'(iter_q - CW'(1));
      RD_OUT:       raddr = out_k_q;
      default:      raddr = '0;
    endcase
  end

  // an accepted input item takes priority; the sorter never writes while collecting
  always_comb begin
    we    = 1'b0;
    waddr = AW'(count_q);
    wdata = in_value_i;
    if (cmd_i.accept) begin
      we = !full;
    end else if (cmd_i.wr_en) begin
      we = 1'b1;
      unique case (cmd_i.wr_sel)
        WR_POS_CHILD: begin
          waddr = AW'(pos_q - CW'(1));
          wdata = cval_q;
        end
        WR_POS_HELD: begin
          waddr = AW'(pos_q - CW'(1));
          wdata = held_q;
        end
        WR_ROOT_RDATA: begin
          waddr = '0;
          wdata = rdata_q;
        end
        WR_ITER_HELD: begin
          waddr = AW'(iter_q - CW'(1));
          wdata = held_q;
        end
        default: begin
          waddr = '0;
          wdata = held_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        if (full) begin
          drop_q <= 1'b1;
        end else begin
          count_q <= count_q + CW'(1);
        end
      end else if (cmd_i.set_clear) begin
        count_q <= '0;
        drop_q  <= 1'b0;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.held_ld) begin
      held_q <= rdata_q;
    end
    if (cmd_i.cval_ld_left) begin
      cval_q <= rdata_q;
      cidx_q <= CW'(kid_q);
    end else if (cmd_i.cval_ld_right && ($signed(cval_q) < $signed(rdata_q))) begin
      cval_q <= rdata_q;
      cidx_q <= CW'(kid_q + KW'(1));
    end
    if (cmd_i.step_down) begin
      pos_q <= cidx_q;
      kid_q <= {cidx_q, 1'b0};
    end else if (cmd_i.sift_build) begin
      pos_q  <= iter_q;
      size_q <= count_q;
      kid_q  <= {iter_q, 1'b0};
      iter_q <= iter_q - CW'(1);
    end else if (cmd_i.sift_extract) begin
      pos_q  <= CW'(1);
      size_q <= iter_q - CW'(1);
      kid_q  <= KW'(2);
      iter_q <= iter_q - CW'(1);
    end else if (cmd_i.iter_ld_half) begin
      iter_q <= count_q >> 1;
    end else if (cmd_i.iter_ld_count) begin
      iter_q <= count_q;
    end
    if (cmd_i.out_k_clr) begin
      out_k_q <= '0;
    end else if (cmd_i.out_k_inc) begin
      out_k_q <= out_k_q + AW'(1);
    end
    if (cmd_i.out_load) begin
      out_value_q <= rdata_q;
      out_rank_q  <= RANK_W'(out_k_q);
      out_final_q <= sts_o.out_last;
      out_ovf_q   <= drop_q;
    end
  end

  assign sts_o.kid_gt_size  = (kid_q > {1'b0, size_q});
  assign sts_o.kid_lt_size  = (kid_q < {1'b0, size_q});
  assign sts_o.held_lt_cval = ($signed(held_q) < $signed(cval_q));
  assign sts_o.iter_zero    = (iter_q == '0);
  assign sts_o.iter_lt2     = (iter_q < CW'(2));
  assign sts_o.out_free     = !out_valid_q || out_ready_i;
  assign sts_o.out_last     = ((CW'(out_k_q) + CW'(1)) == count_q);

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_rank_o  = out_rank_q;
  assign out_final_o = out_final_q;
  assign out_ovf_o   = out_ovf_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ELEMENTS))
    else $error("element count beyond store capacity");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !out_valid_q)
    else $error("output register loaded while a result still waits");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && !full) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("stored element not counted");

endmodule

`default_nettype wire

// File: rtl/core/hs_ctrl.sv
// sequencing state machine of the heap sorter
`timescale 1ns / 1ps
`default_nettype none

module hs_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            in_final_i,
  output logic                 in_ready_o,
  output hs_pkg::hs_cmd_t      cmd_o,
  input  wire hs_pkg::hs_sts_t sts_i
);
  import hs_pkg::*;

  localparam logic [3:0] ST_COLLECT  = 4'd0;
  localparam logic [3:0] ST_B_START  = 4'd1;
  localparam logic [3:0] ST_B_NEXT   = 4'd2;
  localparam logic [3:0] ST_HELD_RD  = 4'd3;
  localparam logic [3:0] ST_HELD_CAP = 4'd4;
  localparam logic [3:0] ST_TEST     = 4'd5;
  localparam logic [3:0] ST_LEFT     = 4'd6;
  localparam logic [3:0] ST_RIGHT    = 4'd7;
  localparam logic [3:0] ST_CMP      = 4'd8;
  localparam logic [3:0] ST_PUT      = 4'd9;
  localparam logic [3:0] ST_X_NEXT   = 4'd10;
  localparam logic [3:0] ST_X_RDI    = 4'd11;
  localparam logic [3:0] ST_X_WR0    = 4'd12;
  localparam logic [3:0] ST_X_WRI    = 4'd13;
  localparam logic [3:0] ST_O_RD     = 4'd14;
  localparam logic [3:0] ST_O_LD     = 4'd15;

  localparam logic PH_BUILD   = 1'b0;
  localparam logic PH_EXTRACT = 1'b1;

  logic [3:0] state_q, state_d;
  logic       phase_q, phase_d;

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_COLLECT: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && in_final_i) begin
          state_d = ST_B_START;
        end
      end
      ST_B_START: begin
        cmd_o.iter_ld_half = 1'b1;
        state_d            = ST_B_NEXT;
      end
      ST_B_NEXT: begin
        if (sts_i.iter_zero) begin
          cmd_o.iter_ld_count = 1'b1;
          state_d             = ST_X_NEXT;
        end else begin
          cmd_o.sift_build = 1'b1;
          phase_d          = PH_BUILD;
          state_d          = ST_HELD_RD;
        end
      end
      ST_HELD_RD: begin
        cmd_o.rd_sel = RD_POS;
        state_d      = ST_HELD_CAP;
      end
      ST_HELD_CAP: begin
        cmd_o.held_ld = 1'b1;
        state_d       = ST_TEST;
      end
      ST_TEST: begin
        if (sts_i.kid_gt_size) begin
          state_d = ST_PUT;
        end else begin
          cmd_o.rd_sel = RD_KID_LEFT;
          state_d      = ST_LEFT;
        end
      end
      ST_LEFT: begin
        cmd_o.cval_ld_left = 1'b1;
        if (sts_i.kid_lt_size) begin
          cmd_o.rd_sel = RD_KID_RIGHT;
          state_d      = ST_RIGHT;
        end else begin
          state_d = ST_CMP;
        end
      end
      ST_RIGHT: begin
        cmd_o.cval_ld_right = 1'b1;
        state_d             = ST_CMP;
      end
      ST_CMP: begin
        // larger child moves up one level, held value keeps sinking
        if (sts_i.held_lt_cval) begin
          cmd_o.wr_en     = 1'b1;
          cmd_o.wr_sel    = WR_POS_CHILD;
          cmd_o.step_down = 1'b1;
          state_d         = ST_TEST;
        end else begin
          state_d = ST_PUT;
        end
      end
      ST_PUT: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_POS_HELD;
        state_d      = (phase_q == PH_BUILD) ? ST_B_NEXT : ST_X_NEXT;
      end
      ST_X_NEXT: begin
        if (sts_i.iter_lt2) begin
          cmd_o.out_k_clr = 1'b1;
          state_d         = ST_O_RD;
        end else begin
          cmd_o.rd_sel = RD_ROOT;
          state_d      = ST_X_RDI;
        end
      end
      ST_X_RDI: begin
        cmd_o.rd_sel  = RD_ITER;
        cmd_o.held_ld = 1'b1;
        state_d       = ST_X_WR0;
      end
      ST_X_WR0: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_ROOT_RDATA;
        state_d      = ST_X_WRI;
      end
      ST_X_WRI: begin
        cmd_o.wr_en        = 1'b1;
        cmd_o.wr_sel       = WR_ITER_HELD;
        cmd_o.sift_extract = 1'b1;
        phase_d            = PH_EXTRACT;
        state_d            = ST_HELD_RD;
      end
      ST_O_RD: begin
        if (sts_i.out_free) begin
          cmd_o.rd_sel = RD_OUT;
          state_d      = ST_O_LD;
        end
      end
      ST_O_LD: begin
        cmd_o.out_load = 1'b1;
        if (sts_i.out_last) begin
          cmd_o.set_clear = 1'b1;
          state_d         = ST_COLLECT;
        end else begin
          cmd_o.out_k_inc = 1'b1;
          state_d         = ST_O_RD;
        end
      end
      default: begin
        state_d = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
      phase_q <= PH_BUILD;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  a_final_starts_sort : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_final_i) |=> (state_q == ST_B_START))
    else $error("final transaction did not start the sort");

  a_load_after_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_O_LD) |-> ($past(state_q) == ST_O_RD))
    else $error("result loaded without a preceding store read");

endmodule

`default_nettype wire

// File: tb/tb_heap_sorter_core.sv
// testbench for heap_sorter_core: random and directed sets checked against a sorting predictor
`timescale 1ns / 1ps

module tb_heap_sorter_core;
  import hs_pkg::*;

  localparam int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF;
  localparam int RAND_ITEMS  = 205;
  localparam int STUCK_LIMIT = 20000;
  localparam int DIR_N       = 25;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [RANK_W-1:0]  rank;
    logic               last;
    logic               ovf;
  } sorted_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               fin;
    logic               typed;
    sorted_t            exp;
  } stim_row_t;

  // typed rows are one-element sets whose single result is obvious
  localparam stim_row_t DIR_TBL [DIR_N] = '{
    '{32'h8000_0000, 1'b1, 1'b1, '{32'h8000_0000, 6'd0, 1'b1, 1'b0}},
    '{32'h7fff_ffff, 1'b1, 1'b1, '{32'h7fff_ffff, 6'd0, 1'b1, 1'b0}},
    '{32'h0000_0000, 1'b1, 1'b1, '{32'h0000_0000, 6'd0, 1'b1, 1'b0}},
    '{32'hffff_ffff, 1'b1, 1'b1, '{32'hffff_ffff, 6'd0, 1'b1, 1'b0}},
    '{32'h7fff_ffff, 1'b0, 1'b0, '0},
    '{32'h0000_0000, 1'b0, 1'b0, '0},
    '{32'h8000_0000, 1'b0, 1'b0, '0},
    '{32'hffff_ffff, 1'b0, 1'b0, '0},
    '{32'h0000_0001, 1'b1, 1'b0, '0},
    '{32'h0000_0005, 1'b0, 1'b0, '0},
    '{32'h0000_0006, 1'b1, 1'b0, '0},
    '{32'h0000_0006, 1'b0, 1'b0, '0},
    '{32'h0000_0005, 1'b1, 1'b0, '0},
    '{32'h0000_0003, 1'b0, 1'b0, '0},
    '{32'h0000_0003, 1'b0, 1'b0, '0},
    '{32'h0000_0003, 1'b1, 1'b0, '0},
    '{32'hffff_fffe, 1'b0, 1'b0, '0},
    '{32'h0000_0007, 1'b0, 1'b0, '0},
    '{32'hffff_fffe, 1'b0, 1'b0, '0},
    '{32'h0000_0007, 1'b1, 1'b0, '0},
    '{32'h0000_0028, 1'b0, 1'b0, '0},
    '{32'h0000_001e, 1'b0, 1'b0, '0},
    '{32'h0000_0014, 1'b0, 1'b0, '0},
    '{32'h0000_000a, 1'b0, 1'b0, '0},
    '{32'h0000_0000, 1'b1, 1'b0, '0}
  };

  logic clk_i;
  logic rst_ni;

  hs_in_if  in_if ();
  hs_out_if out_if ();

  heap_sorter_core #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // predictor state
  logic [VALUE_W-1:0] elem_store [MAX_ELEMENTS];
  int unsigned        elem_count;
  logic               drop_seen;
  sorted_t            sorted_exp_q [$];

  stim_row_t cur_row;
  logic      steady;
  int        stuck_cycles;
  int        error_cnt;
  int        results_checked;
  int        sets_done;
  int        ovf_sets;
  int        max_set;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // store one sample; a final one sorts the set and queues its results
  function automatic void absorb_sample(input stim_row_t row);
    logic [VALUE_W-1:0] tmp;
    sorted_t            res;
    int                 n;
    int                 b;
    if (elem_count < MAX_ELEMENTS) begin
      elem_store[elem_count] = row.value;
      elem_count++;
    end else begin
      drop_seen = 1'b1;
    end
    if (row.fin) begin
      n = elem_count;
      for (int a = 1; a < n; a++) begin
        tmp = elem_store[a];
        b = a;
        while (b > 0 && $signed(elem_store[b-1]) > $signed(tmp)) begin
          elem_store[b] = elem_store[b-1];
          b--;
        end
        elem_store[b] = tmp;
      end
      if (row.typed) begin
        sorted_exp_q.push_back(row.exp);
      end else begin
        for (int k = 0; k < n; k++) begin
          res.value = elem_store[k];
          res.rank  = RANK_W'(k);
          res.last  = (k == n - 1);
          res.ovf   = drop_seen;
          sorted_exp_q.push_back(res);
        end
      end
      sets_done++;
      if (drop_seen) ovf_sets++;
      if (n > max_set) max_set = n;
      elem_count = 0;
      drop_seen  = 1'b0;
    end
  endfunction

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic drive_sample(input stim_row_t row);
    while (!steady && $urandom_range(99) < 9) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    cur_row = row;
    in_if.valid        <= 1'b1;
    in_if.sample_value <= row.value;
    in_if.is_final     <= row.fin;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_if.ready <= steady || ($urandom_range(99) >= 9);
  end

  always @(posedge clk_i) begin
    sorted_t got;
    sorted_t want;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) absorb_sample(cur_row);
      if (out_if.valid && out_if.ready) begin
        got.value = out_if.sorted_value;
        got.rank  = out_if.rank;
        got.last  = out_if.final_out;
        got.ovf   = out_if.overflowed;
        if (sorted_exp_q.size() == 0) begin
          error_cnt++;
          if (error_cnt <= 10)
            $display("%0t: unexpected result value=%0d rank=%0d last=%b ovf=%b", $realtime,
                     $signed(got.value), got.rank, got.last, got.ovf);
        end else begin
          want = sorted_exp_q.pop_front();
          results_checked++;
          if (got.value !== want.value || got.rank !== want.rank ||
              got.last !== want.last || got.ovf !== want.ovf) begin
            error_cnt++;
            if (error_cnt <= 10)
              $display({"%0t: mismatch exp value=%0d rank=%0d last=%b ovf=%b,",
                        " got value=%0d rank=%0d last=%b ovf=%b"},
                       $realtime, $signed(want.value), want.rank, want.last, want.ovf,
                       $signed(got.value), got.rank, got.last, got.ovf);
          end
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        stuck_cycles <= 0;
      else
        stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk_i);
    $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
             STUCK_LIMIT, sorted_exp_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    stim_row_t row;
    int        rand_items;
    int        set_idx;
    int        set_len;
    rand_items         = 0;
    set_idx            = 0;
    elem_count         = 0;
    drop_seen          = 1'b0;
    stuck_cycles       = 0;
    error_cnt          = 0;
    results_checked    = 0;
    sets_done          = 0;
    ovf_sets           = 0;
    max_set            = 0;
    steady             = 1'b0;
    cur_row            = '0;
    in_if.valid        = 1'b0;
    in_if.sample_value = '0;
    in_if.is_final     = 1'b0;
    out_if.ready       = 1'b0;
    rst_ni             = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < DIR_N; i++) drive_sample(DIR_TBL[i]);

    while (rand_items < RAND_ITEMS) begin
      // one full set and one set that spills past the store, final included
      if (set_idx == 2)
        set_len = MAX_ELEMENTS;
      else if (set_idx == 5)
        set_len = MAX_ELEMENTS + $urandom_range(1, 4);
      else if ($urandom_range(9) == 0)
        set_len = $urandom_range(11, 30);
      else
        set_len = $urandom_range(1, 10);
      steady = (set_idx >= 8 && set_idx < 14);
      for (int j = 0; j < set_len; j++) begin
        row = '0;
        case ($urandom_range(19))
          0, 1, 2: begin
            case ($urandom_range(4))
              0: row.value = 32'h8000_0000;
              1: row.value = 32'h7fff_ffff;
              2: row.value = 32'h0000_0000;
              3: row.value = 32'hffff_ffff;
              default: row.value = 32'h0000_0001;
            endcase
          end
          3, 4, 5, 6, 7: row.value = $urandom_range(7) - 3;
          default: row.value = $urandom;
        endcase
        row.fin = (j == set_len - 1);
        drive_sample(row);
        rand_items++;
      end
      set_idx++;
    end
    in_if.valid <= 1'b0;
    steady = 1'b0;

    while (sorted_exp_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("sorted %0d sets (%0d with dropped elements, largest %0d), %0d results checked",
             sets_done, ovf_sets, max_set, results_checked);
    $display("%0d mismatches, %0d results still outstanding", error_cnt, sorted_exp_q.size());
    if (error_cnt == 0 && sorted_exp_q.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/hs_pkg.sv
rtl/core/hs_if.sv
rtl/core/hs_datapath.sv
rtl/core/hs_ctrl.sv
rtl/core/heap_sorter_core.sv
tb/tb_heap_sorter_core.sv
